>>> design/mtd_pkg.sv
// Package for the Morse text decoder: sizes, op and result codes, queue item type.
// Used by every module of the block but mtd_ram; depends on nothing.
package mtd_pkg;

    localparam int TableEntries = 64;
    localparam int MaxSymbols   = 16;
    localparam int QueueDepth   = 4;

    localparam int CodeW  = 32;
    localparam int CharW  = 8;
    localparam int LenW   = 5;
    localparam int IdxW   = $clog2(TableEntries);
    localparam int UsedW  = $clog2(TableEntries + 1);
    localparam int QPtrW  = $clog2(QueueDepth);
    localparam int QCntW  = $clog2(QueueDepth + 1);

    localparam logic [CharW-1:0] CharSlash   = 8'h2F;
    localparam logic [CharW-1:0] CharDot     = 8'h2E;
    localparam logic [CharW-1:0] CharDash    = 8'h2D;
    localparam logic [CharW-1:0] CharNewline = 8'h0A;
    localparam logic [CharW-1:0] CharSpace   = 8'h20;

    localparam logic [1:0] SymDot  = 2'd1;
    localparam logic [1:0] SymDash = 2'd2;
    localparam logic [1:0] SlashMax = 2'd3;
    localparam logic [1:0] SlashWord = 2'd2;

    typedef enum logic [2:0] {
        KIND_LETTER  = 3'd0,
        KIND_SPACE   = 3'd1,
        KIND_UNKNOWN = 3'd2,
        KIND_INVALID = 3'd3,
        KIND_FULL    = 3'd4
    } t_kind;

    // work handed from the front to the back
    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_UNKNOWN,
        OP_SPACE,
        OP_INVALID,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CodeW-1:0]   code;
        logic [LenW-1:0]    len;
        logic [CharW-1:0]   ch;
    } t_op_item;

    typedef struct packed {
        logic     valid;
        t_op_item item;
    } t_q_port;

endpackage

>>> design/morse_text_decoder_top.sv
// Top level of the Morse text decoder: front, op queue and back.
// Depends on mtd_pkg, mtd_front, mtd_queue, mtd_back (and mtd_ram below it).
//
// Usage:
//  - Input channel (i_valid / o_stall): one item per accept. i_req_type 0 carries
//    one ASCII character of Morse text in i_in_char; 1 loads a table entry from
//    i_entry_code / i_entry_letter.
//  - Output channel (o_valid / i_stall): at most one result item per input item,
//    in input order: letter, word space, unknown sequence (code and length),
//    invalid character, or table full.
//  - Throughput: one item per cycle while o_stall is low. The table compare over all
//    64 keys and the letter RAM read happen in the same back-end cycle, so the back
//    retires one op a cycle unless i_stall holds the result register. An accepted item
//    is written into the queue, then, at the head with the output free, into the result register.
//  - A receiver stall holds the result register; the 4-entry queue keeps taking
//    items until it fills, then o_stall rises.
//  - Reset (synchronous, active low) clears the text state, the queue, the table
//    valid bits and fill count. Letter storage is not cleared; it is only read
//    at entries that a load has written.
module morse_text_decoder_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_req_type,
    input  logic [mtd_pkg::CharW-1:0] i_in_char,
    input  logic [mtd_pkg::CodeW-1:0] i_entry_code,
    input  logic [mtd_pkg::CharW-1:0] i_entry_letter,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_result_kind,
    output logic [mtd_pkg::CharW-1:0] o_out_char,
    output logic [mtd_pkg::CodeW-1:0] o_bad_code,
    output logic [mtd_pkg::LenW-1:0]  o_bad_length
);

    mtd_pkg::t_q_port push;
    mtd_pkg::t_q_port head;
    logic             q_full;
    logic             pop;
    logic             accept;

    // queue full blocks every item, even ones that would push nothing
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    mtd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req_type),
        .i_in_char      (i_in_char),
        .i_entry_code   (i_entry_code),
        .i_entry_letter (i_entry_letter),
        .o_push         (push)
    );

    mtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    mtd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_out_char    (o_out_char),
        .o_bad_code    (o_bad_code),
        .o_bad_length  (o_bad_length)
    );

endmodule

>>> design/mtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module mtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mtd_front.sv
// Front of the decoder: tracks Morse text state and turns each item into a queue op.
// Depends on mtd_pkg.
module mtd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_req_type,
    input  logic [mtd_pkg::CharW-1:0] i_in_char,
    input  logic [mtd_pkg::CodeW-1:0] i_entry_code,
    input  logic [mtd_pkg::CharW-1:0] i_entry_letter,
    output mtd_pkg::t_q_port          o_push
);

    logic [mtd_pkg::CodeW-1:0] r_code, n_code;
    logic [mtd_pkg::LenW-1:0]  r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic [1:0]                r_slash, n_slash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_slash <= '0;
        end else if (i_accept) begin
            r_code  <= n_code;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_slash <= n_slash;
        end
    end

    always_comb begin
        logic is_slash;
        logic is_nl;
        logic is_sym;
        is_slash = (i_in_char == mtd_pkg::CharSlash);
        is_nl    = (i_in_char == mtd_pkg::CharNewline);
        is_sym   = (i_in_char == mtd_pkg::CharDot) || (i_in_char == mtd_pkg::CharDash);

        n_code  = r_code;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_slash = r_slash;

        o_push.valid     = 1'b0;
        o_push.item.op   = mtd_pkg::OP_INVALID;
        o_push.item.code = '0;
        o_push.item.len  = '0;
        o_push.item.ch   = '0;

        if (i_req_type) begin
            o_push.valid     = i_accept;
            o_push.item.op   = mtd_pkg::OP_LOAD;
            o_push.item.code = i_entry_code;
            o_push.item.ch   = i_entry_letter;
        end else begin
            if (is_slash) begin
                n_slash = (r_slash < mtd_pkg::SlashMax) ? r_slash + 2'd1 : mtd_pkg::SlashMax;
            end else begin
                n_slash = '0;
            end

            if (is_sym) begin
                n_code = {r_code[mtd_pkg::CodeW-3:0],
                          (i_in_char == mtd_pkg::CharDot) ? mtd_pkg::SymDot : mtd_pkg::SymDash};
                if (r_count >= mtd_pkg::LenW'(mtd_pkg::MaxSymbols)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else if ((is_slash || is_nl) && (r_count != '0)) begin
                // flush; overflowed codes skip the table
                o_push.valid     = i_accept;
                o_push.item.op   = r_ovf ? mtd_pkg::OP_UNKNOWN : mtd_pkg::OP_LOOKUP;
                o_push.item.code = r_code;
                o_push.item.len  = r_count;
                n_code  = '0;
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (is_slash && (n_slash == mtd_pkg::SlashWord)) begin
                o_push.valid   = i_accept;
                o_push.item.op = mtd_pkg::OP_SPACE;
            end else if (!is_nl) begin
                o_push.valid   = i_accept;
                o_push.item.op = mtd_pkg::OP_INVALID;
                o_push.item.ch = i_in_char;
            end
        end
    end

endmodule

>>> design/mtd_queue.sv
// Short op queue between front and back.
// Depends on mtd_pkg.
module mtd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtd_pkg::t_q_port i_push,
    input  logic             i_pop,
    output mtd_pkg::t_q_port o_head,
    output logic             o_full
);

    mtd_pkg::t_op_item               r_mem [mtd_pkg::QueueDepth];
    logic [mtd_pkg::QPtrW-1:0]       r_wr, r_rd;
    logic [mtd_pkg::QCntW-1:0]       r_cnt;
    logic                            do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == mtd_pkg::QPtrW'(mtd_pkg::QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == mtd_pkg::QPtrW'(mtd_pkg::QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + mtd_pkg::QCntW'(i_push.valid) - mtd_pkg::QCntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];
    assign o_full       = (r_cnt == mtd_pkg::QCntW'(mtd_pkg::QueueDepth));

endmodule

>>> design/mtd_back.sv
// Back of the decoder: table keys with parallel compare, letter RAM, result register.
// Depends on mtd_pkg and mtd_ram.
module mtd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mtd_pkg::t_q_port          i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_result_kind,
    output logic [mtd_pkg::CharW-1:0] o_out_char,
    output logic [mtd_pkg::CodeW-1:0] o_bad_code,
    output logic [mtd_pkg::LenW-1:0]  o_bad_length
);

    logic [mtd_pkg::CodeW-1:0] r_key [mtd_pkg::TableEntries];
    logic [mtd_pkg::TableEntries-1:0] r_kvalid;
    logic [mtd_pkg::UsedW-1:0] r_used;

    logic                      r_valid, n_valid;
    mtd_pkg::t_kind            r_kind, n_kind;
    logic [mtd_pkg::CharW-1:0] r_char, n_char;
    logic [mtd_pkg::CodeW-1:0] r_code, n_code;
    logic [mtd_pkg::LenW-1:0]  r_len, n_len;

    logic [mtd_pkg::TableEntries-1:0] hit_vec;
    logic                      any_hit;
    logic [mtd_pkg::IdxW-1:0]  hit_idx;
    logic                      advance;
    logic                      ram_we, ram_re;
    logic [mtd_pkg::IdxW-1:0]  ram_waddr;
    logic [mtd_pkg::CharW-1:0] ram_rdata;
    logic                      add_key;
    logic                      room;

    assign advance = !r_valid || !i_stall;
    assign o_pop   = advance && i_head.valid;
    assign room    = (r_used < mtd_pkg::UsedW'(mtd_pkg::TableEntries));

    // keys are unique, so OR-ing the matching indexes gives the hit index
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < mtd_pkg::TableEntries; i++) begin
            hit_vec[i] = r_kvalid[i] && (r_key[i] == i_head.item.code);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | mtd_pkg::IdxW'(i);
            end
        end
        any_hit = |hit_vec;
    end

    always_comb begin
        n_valid   = r_valid && i_stall;
        n_kind    = r_kind;
        n_char    = r_char;
        n_code    = r_code;
        n_len     = r_len;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = hit_idx;
        add_key   = 1'b0;
        if (o_pop) begin
            n_valid = 1'b1;
            n_char  = '0;
            n_code  = '0;
            n_len   = '0;
            unique case (i_head.item.op)
                mtd_pkg::OP_LOOKUP: begin
                    if (any_hit) begin
                        n_kind = mtd_pkg::KIND_LETTER;
                        ram_re = 1'b1;
                    end else begin
                        n_kind = mtd_pkg::KIND_UNKNOWN;
                        n_code = i_head.item.code;
                        n_len  = i_head.item.len;
                    end
                end
                mtd_pkg::OP_UNKNOWN: begin
                    n_kind = mtd_pkg::KIND_UNKNOWN;
                    n_code = i_head.item.code;
                    n_len  = i_head.item.len;
                end
                mtd_pkg::OP_SPACE: begin
                    n_kind = mtd_pkg::KIND_SPACE;
                    n_char = mtd_pkg::CharSpace;
                end
                mtd_pkg::OP_INVALID: begin
                    n_kind = mtd_pkg::KIND_INVALID;
                    n_char = i_head.item.ch;
                end
                mtd_pkg::OP_LOAD: begin
                    n_kind = mtd_pkg::KIND_FULL;
                    if (any_hit) begin
                        n_valid = 1'b0;
                        ram_we  = 1'b1;
                    end else if (room) begin
                        n_valid   = 1'b0;
                        ram_we    = 1'b1;
                        ram_waddr = r_used[mtd_pkg::IdxW-1:0];
                        add_key   = 1'b1;
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_kvalid <= '0;
            r_used   <= '0;
        end else begin
            r_valid <= n_valid;
            if (add_key) begin
                r_kvalid[r_used[mtd_pkg::IdxW-1:0]] <= 1'b1;
                r_used <= r_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_char <= n_char;
        r_code <= n_code;
        r_len  <= n_len;
        if (add_key) begin
            r_key[r_used[mtd_pkg::IdxW-1:0]] <= i_head.item.code;
        end
    end

    mtd_ram #(
        .WIDTH (mtd_pkg::CharW),
        .DEPTH (mtd_pkg::TableEntries)
    ) u_letters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_head.item.ch),
        .i_re    (ram_re),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_out_char    = (r_kind == mtd_pkg::KIND_LETTER) ? ram_rdata : r_char;
    assign o_bad_code    = r_code;
    assign o_bad_length  = r_len;

endmodule
